// ===== rtl/sgr_pkg.sv =====
// shared types, constants and font table of the scaled glyph rectangle generator
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int GLYPH_COUNT  = 36;
    localparam int GLYPH_ALPHA  = 26;
    localparam int GLYPH_BITS   = 40;
    localparam int ADDR_BITS_DEF = 24;
    localparam int PIX_ADDR_W   = 24;
    localparam int COORD_W      = 18;
    localparam int PEN_W        = 16;
    localparam int PIX_W        = 12;
    localparam int DIM_W        = 13;
    localparam int COLOR_W      = 32;
    localparam int SCALE_W      = 4;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int PEN_STEP     = 6;
    localparam int PEN_MAX      = 32767;
    localparam int CLIP_MAX     = 4096;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 104;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd1080;
    localparam logic [DIM_W-1:0]   RST_LINE_STRIDE   = 13'd1920;
    localparam logic [COLOR_W-1:0] RST_INK_COLOR     = 32'h0000ff66;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_LINE_STRIDE   = 2'd2,
        CFG_INK_COLOR     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] y_last;
        logic [PIX_W-1:0] x_last;
        logic [PIX_W-1:0] y_first;
        logic [PIX_W-1:0] x_first;
    } t_rect;

    typedef struct packed {
        logic  valid;
        logic  last;
        t_rect rect;
    } t_push;

    // byte c of an entry is column c, bit r of that byte is row r
    localparam logic [GLYPH_BITS-1:0] FONT [GLYPH_COUNT] = '{
        40'h7e1111117e, 40'h364949497f, 40'h224141413e, 40'h1c2241417f,
        40'h414949497f, 40'h010909097f, 40'h7a4949413e, 40'h7f0808087f,
        40'h00417f4100, 40'h013f414020, 40'h412214087f, 40'h404040407f,
        40'h7f020c027f, 40'h7f1008047f, 40'h3e4141413e, 40'h060909097f,
        40'h5e2151413e, 40'h462919097f, 40'h3149494946, 40'h01017f0101,
        40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
        40'h0708700807, 40'h4345495161, 40'h3e4549513e, 40'h00407f4200,
        40'h4649516142, 40'h314b454121, 40'h107f121418, 40'h3945454527,
        40'h3049494a3c, 40'h0305097101, 40'h3649494936, 40'h1e29494906
    };

    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
        logic [GLYPH_BITS-1:0] bits;
        bits = '0;
        if (code >= CHAR_A && code <= CHAR_Z) begin
            bits = FONT[6'(code - CHAR_A)];
        end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            bits = FONT[6'(code - CHAR_ZERO) + 6'(GLYPH_ALPHA)];
        end
        return bits;
    endfunction

endpackage

// ===== rtl/sgr_dot_unit.sv =====
// clip unit: turns one dot square into a screen-clipped rectangle
`timescale 1ns / 1ps

module sgr_dot_unit (
    input  logic signed [sgr_pkg::COORD_W-1:0] i_x_lo,
    input  logic signed [sgr_pkg::COORD_W-1:0] i_y_lo,
    input  logic        [sgr_pkg::SCALE_W-1:0] i_scale,
    input  logic        [sgr_pkg::DIM_W-1:0]   i_lim_w,
    input  logic        [sgr_pkg::DIM_W-1:0]   i_lim_h,
    output logic                               o_vis,
    output sgr_pkg::t_rect                     o_rect
);

    typedef struct packed {
        logic                      vis;
        logic [sgr_pkg::PIX_W-1:0] a;
        logic [sgr_pkg::PIX_W-1:0] b;
    } t_span;

    function automatic t_span clip_span(input logic signed [sgr_pkg::COORD_W-1:0] lo,
                                        input logic [sgr_pkg::SCALE_W-1:0] len,
                                        input logic [sgr_pkg::DIM_W-1:0] lim);
        t_span                              sp;
        logic signed [sgr_pkg::COORD_W-1:0] hi;
        logic signed [sgr_pkg::COORD_W-1:0] lim_s;
        lim_s = $signed({{(sgr_pkg::COORD_W-sgr_pkg::DIM_W){1'b0}}, lim});
        hi    = lo + $signed({{(sgr_pkg::COORD_W-sgr_pkg::SCALE_W){1'b0}}, len})
                - sgr_pkg::COORD_W'(1);
        sp.vis = (lim != '0) && (hi >= 0) && (lo < lim_s);
        sp.a   = (lo < 0) ? '0 : lo[sgr_pkg::PIX_W-1:0];
        sp.b   = (hi >= lim_s) ? sgr_pkg::PIX_W'(lim - sgr_pkg::DIM_W'(1))
                               : hi[sgr_pkg::PIX_W-1:0];
        return sp;
    endfunction

    t_span x_span;
    t_span y_span;

    assign x_span = clip_span(i_x_lo, i_scale, i_lim_w);
    assign y_span = clip_span(i_y_lo, i_scale, i_lim_h);

    assign o_vis          = x_span.vis & y_span.vis;
    assign o_rect.x_first = x_span.a;
    assign o_rect.x_last  = x_span.b;
    assign o_rect.y_first = y_span.a;
    assign o_rect.y_last  = y_span.b;

endmodule

// ===== rtl/sgr_out_stage.sv =====
// output register with address multiplier for finished rectangles
`timescale 1ns / 1ps

module sgr_out_stage #(
    parameter int ADDR_BITS = sgr_pkg::ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sgr_pkg::t_push                        i_push,
    input  logic [sgr_pkg::DIM_W-1:0]             i_stride,
    input  logic [sgr_pkg::COLOR_W-1:0]           i_ink,
    output logic                                  o_free,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [sgr_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int SUM_W = sgr_pkg::PIX_W + sgr_pkg::DIM_W + 1;
    localparam logic [SUM_W-1:0] ADDR_MASK =
        (ADDR_BITS >= SUM_W) ? {SUM_W{1'b1}} : SUM_W'((64'(1) << ADDR_BITS) - 64'(1));

    logic                                  r_valid;
    logic [sgr_pkg::OUT_DATA_W-1:0]        r_data;
    logic                                  r_last;
    logic [SUM_W-1:0]                      addr_sum;
    logic [sgr_pkg::PIX_ADDR_W-1:0]        addr;

    assign addr_sum = SUM_W'(i_push.rect.y_first) * SUM_W'(i_stride)
                    + SUM_W'(i_push.rect.x_first);
    assign addr     = sgr_pkg::PIX_ADDR_W'(addr_sum & ADDR_MASK);
    assign o_free   = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data <= {i_ink, i_push.rect.y_last, i_push.rect.x_last,
                       i_push.rect.y_first, i_push.rect.x_first, addr};
            r_last <= i_push.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

// ===== rtl/scaled_glyph_rectangle_generator.sv =====
// top level: config registers, pen, dot sequencer and output stage
`timescale 1ns / 1ps

// one character item in on the s side, one rectangle item per visible lit dot
// out on the m side, tlast on the final rectangle of a character.
// the user writes config via i_cfg_we / i_cfg_index / i_cfg_data only while
// idle; the block does not enforce it. an accepted item is scanned as 5
// columns by 7 rows, one dot a cycle through the shared clip unit while the
// output register can take one, so a character holds the input over 35 dots
// plus a flush of the last held rectangle; a zero scale item starts no scan.
// each rectangle waits for the next visible dot or the scan end so tlast can
// be set, then goes through the address multiplier into the output register.
// o_s_tready is high only while no character is being scanned; the output
// register lets the next character be taken while the last rectangle waits.
// when the receiver stalls with the output register full, the scan freezes.
// reset loads default screen 1920x1080, stride 1920, ink 0x0000ff66, pen 0,
// and empties the output register.
module scaled_glyph_rectangle_generator #(
    parameter int ADDR_BITS = sgr_pkg::ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // char_code, origin_x, origin_y, dot_scale
    input  logic [sgr_pkg::IN_DATA_W-1:0]         i_s_tdata,
    // new_string
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // pixel_address, x_first, y_first, x_last, y_last, fill_color
    output logic [sgr_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_we,
    input  logic [sgr_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [sgr_pkg::COLOR_W-1:0]           i_cfg_data
);

    localparam int PEN_SUM_W = sgr_pkg::PEN_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // config registers
    logic [sgr_pkg::DIM_W-1:0]   r_lim_w;
    logic [sgr_pkg::DIM_W-1:0]   r_lim_h;
    logic [sgr_pkg::DIM_W-1:0]   r_stride;
    logic [sgr_pkg::COLOR_W-1:0] r_ink;
    logic [sgr_pkg::DIM_W-1:0]   cfg_dim;
    logic [sgr_pkg::DIM_W-1:0]   cfg_lim;

    // sequencer
    t_state                              r_state, n_state;
    logic signed [sgr_pkg::PEN_W-1:0]    r_pen, n_pen;
    logic                                r_hold_v, n_hold_v;
    sgr_pkg::t_rect                      r_hold, n_hold;
    logic [sgr_pkg::GLYPH_BITS-1:0]      r_glyph, n_glyph;
    logic signed [sgr_pkg::COORD_W-1:0]  r_xlo, n_xlo;
    logic signed [sgr_pkg::COORD_W-1:0]  r_ylo, n_ylo;
    logic signed [sgr_pkg::COORD_W-1:0]  r_oy, n_oy;
    logic [sgr_pkg::SCALE_W-1:0]         r_scale, n_scale;
    logic [2:0]                          r_row, n_row;
    logic [2:0]                          r_col, n_col;

    logic                                accept;
    logic [7:0]                          in_code;
    logic signed [sgr_pkg::DIM_W-1:0]    in_ox;
    logic signed [sgr_pkg::DIM_W-1:0]    in_oy;
    logic [sgr_pkg::SCALE_W-1:0]         in_scale;
    logic signed [PEN_SUM_W-1:0]         pen_load;
    logic signed [PEN_SUM_W-1:0]         pen_adv;
    logic [sgr_pkg::PEN_W-1:0]           pen_sat;
    logic [sgr_pkg::COORD_W-1:0]         scale_ext;

    logic                                out_free;
    logic                                step;
    logic                                dot_vis;
    logic                                vis;
    logic                                end_dot;
    sgr_pkg::t_rect                      dot_rect;
    sgr_pkg::t_push                      push;

    // config port
    assign cfg_dim = i_cfg_data[sgr_pkg::DIM_W-1:0];
    assign cfg_lim = (cfg_dim > sgr_pkg::DIM_W'(sgr_pkg::CLIP_MAX))
                   ? sgr_pkg::DIM_W'(sgr_pkg::CLIP_MAX) : cfg_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_w  <= sgr_pkg::RST_SCREEN_WIDTH;
            r_lim_h  <= sgr_pkg::RST_SCREEN_HEIGHT;
            r_stride <= sgr_pkg::RST_LINE_STRIDE;
            r_ink    <= sgr_pkg::RST_INK_COLOR;
        end else if (i_cfg_we) begin
            unique case (sgr_pkg::t_cfg_reg'(i_cfg_index))
                sgr_pkg::CFG_SCREEN_WIDTH:  r_lim_w  <= cfg_lim;
                sgr_pkg::CFG_SCREEN_HEIGHT: r_lim_h  <= cfg_lim;
                sgr_pkg::CFG_LINE_STRIDE:   r_stride <= cfg_dim;
                sgr_pkg::CFG_INK_COLOR:     r_ink    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    assign in_code  = i_s_tdata[7:0];
    assign in_ox    = $signed(i_s_tdata[20:8]);
    assign in_oy    = $signed(i_s_tdata[33:21]);
    assign in_scale = i_s_tdata[37:34];

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // pen load and advance
    assign pen_load = i_s_tuser ? PEN_SUM_W'(in_ox) : PEN_SUM_W'(r_pen);
    assign pen_adv  = pen_load
                    + $signed({{(PEN_SUM_W-sgr_pkg::SCALE_W){1'b0}}, in_scale} << 2)
                    + $signed({{(PEN_SUM_W-sgr_pkg::SCALE_W){1'b0}}, in_scale} << 1);
    assign pen_sat  = (pen_adv > PEN_SUM_W'(sgr_pkg::PEN_MAX))
                    ? sgr_pkg::PEN_W'(sgr_pkg::PEN_MAX) : pen_adv[sgr_pkg::PEN_W-1:0];

    assign scale_ext = {{(sgr_pkg::COORD_W-sgr_pkg::SCALE_W){1'b0}}, r_scale};

    sgr_dot_unit u_dot (
        .i_x_lo  (r_xlo),
        .i_y_lo  (r_ylo),
        .i_scale (r_scale),
        .i_lim_w (r_lim_w),
        .i_lim_h (r_lim_h),
        .o_vis   (dot_vis),
        .o_rect  (dot_rect)
    );

    assign step    = (r_state == ST_SCAN) && out_free;
    assign vis     = r_glyph[0] && dot_vis;
    assign end_dot = (r_col == 3'(sgr_pkg::GLYPH_COLS - 1))
                  && (r_row == 3'(sgr_pkg::GLYPH_ROWS - 1));

    // held rectangle goes out once the next one is found or the scan ends
    assign push.valid = r_hold_v && ((step && vis) || ((r_state == ST_FLUSH) && out_free));
    assign push.last  = (r_state == ST_FLUSH);
    assign push.rect  = r_hold;

    always_comb begin
        n_state  = r_state;
        n_pen    = r_pen;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_glyph  = r_glyph;
        n_xlo    = r_xlo;
        n_ylo    = r_ylo;
        n_oy     = r_oy;
        n_scale  = r_scale;
        n_row    = r_row;
        n_col    = r_col;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pen    = (in_scale != '0) ? pen_sat : pen_load[sgr_pkg::PEN_W-1:0];
                    n_state  = (in_scale != '0) ? ST_SCAN : ST_IDLE;
                    n_glyph  = sgr_pkg::glyph_bits(in_code);
                    n_xlo    = sgr_pkg::COORD_W'(pen_load);
                    n_ylo    = sgr_pkg::COORD_W'(in_oy);
                    n_oy     = sgr_pkg::COORD_W'(in_oy);
                    n_scale  = in_scale;
                    n_row    = '0;
                    n_col    = '0;
                    n_hold_v = 1'b0;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (vis) begin
                        n_hold   = dot_rect;
                        n_hold_v = 1'b1;
                    end
                    if (r_row == 3'(sgr_pkg::GLYPH_ROWS - 1)) begin
                        n_row   = '0;
                        n_col   = r_col + 3'd1;
                        n_xlo   = r_xlo + $signed(scale_ext);
                        n_ylo   = r_oy;
                        n_glyph = r_glyph >> 2;
                    end else begin
                        n_row   = r_row + 3'd1;
                        n_ylo   = r_ylo + $signed(scale_ext);
                        n_glyph = r_glyph >> 1;
                    end
                    if (end_dot) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_hold_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pen    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pen    <= n_pen;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_glyph <= n_glyph;
        r_xlo   <= n_xlo;
        r_ylo   <= n_ylo;
        r_oy    <= n_oy;
        r_scale <= n_scale;
        r_row   <= n_row;
        r_col   <= n_col;
    end

    sgr_out_stage #(
        .ADDR_BITS (ADDR_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_stride   (r_stride),
        .i_ink      (r_ink),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== tb/sv/tb.sv =====
// testbench of the scaled glyph rectangle generator: predictor, stimulus and result checks
`timescale 1ns / 1ps

module tb;

    // dot columns per glyph in column order, column 0 in the top byte
    localparam logic [0:sgr_pkg::GLYPH_COUNT-1][0:sgr_pkg::GLYPH_COLS-1][7:0] DOT_COLS = {
        40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c,
        40'h7f49494941, 40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f,
        40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906,
        40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
        40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h3e5149453e, 40'h00427f4000,
        40'h4261514946, 40'h2141454b31, 40'h1814127f10, 40'h2745454539,
        40'h3c4a494930, 40'h0171090503, 40'h3649494936, 40'h064949291e
    };

    typedef struct {
        logic [sgr_pkg::PIX_ADDR_W-1:0] addr;
        logic [sgr_pkg::PIX_W-1:0]      x_first;
        logic [sgr_pkg::PIX_W-1:0]      y_first;
        logic [sgr_pkg::PIX_W-1:0]      x_last;
        logic [sgr_pkg::PIX_W-1:0]      y_last;
        logic [sgr_pkg::COLOR_W-1:0]    color;
        logic                           last;
    } t_rect_exp;

    class rect_predictor;
        t_rect_exp      expected_rects[$];
        int             errors;
        int             scr_w;
        int             scr_h;
        int             stride;
        logic [31:0]    ink;
        int             pen;

        function new();
            errors = 0;
            scr_w  = int'(sgr_pkg::RST_SCREEN_WIDTH);
            scr_h  = int'(sgr_pkg::RST_SCREEN_HEIGHT);
            stride = int'(sgr_pkg::RST_LINE_STRIDE);
            ink    = sgr_pkg::RST_INK_COLOR;
            pen    = 0;
        endfunction

        function void set_reg(sgr_pkg::t_cfg_reg idx, logic [31:0] v);
            case (idx)
                sgr_pkg::CFG_SCREEN_WIDTH:  scr_w = int'(v[sgr_pkg::DIM_W-1:0]);
                sgr_pkg::CFG_SCREEN_HEIGHT: scr_h = int'(v[sgr_pkg::DIM_W-1:0]);
                sgr_pkg::CFG_LINE_STRIDE:   stride = int'(v[sgr_pkg::DIM_W-1:0]);
                sgr_pkg::CFG_INK_COLOR:     ink = v;
                default: ;
            endcase
        endfunction

        function bit clip_span(int lo, int len, int lim, output int a, output int b);
            int hi;
            hi = lo + len - 1;
            a = 0;
            b = 0;
            if (lim <= 0 || hi < 0 || lo > lim - 1) return 0;
            a = (lo < 0) ? 0 : lo;
            b = (hi > lim - 1) ? lim - 1 : hi;
            return 1;
        endfunction

        function void take_char(logic [7:0] code, logic ns, logic signed [12:0] ox,
                                logic signed [12:0] oy, logic [3:0] sc);
            int s, w, h, g, xa, xb, ya, yb, added;
            logic [7:0] bits;
            longint unsigned addr;
            t_rect_exp r;
            s = int'(sc);
            w = (scr_w > sgr_pkg::CLIP_MAX) ? sgr_pkg::CLIP_MAX : scr_w;
            h = (scr_h > sgr_pkg::CLIP_MAX) ? sgr_pkg::CLIP_MAX : scr_h;
            added = 0;
            if (ns) pen = int'(ox);
            if (s == 0) return;
            if (code >= sgr_pkg::CHAR_A && code <= sgr_pkg::CHAR_Z) begin
                g = int'(code - sgr_pkg::CHAR_A);
            end else if (code >= sgr_pkg::CHAR_ZERO && code <= sgr_pkg::CHAR_NINE) begin
                g = sgr_pkg::GLYPH_ALPHA + int'(code - sgr_pkg::CHAR_ZERO);
            end else begin
                g = -1;
            end
            for (int col = 0; col < sgr_pkg::GLYPH_COLS; col++) begin
                bits = (g < 0) ? 8'h00 : DOT_COLS[g][col];
                for (int row = 0; row < sgr_pkg::GLYPH_ROWS; row++) begin
                    if (!bits[row]) continue;
                    if (!clip_span(pen + col * s, s, w, xa, xb)) continue;
                    if (!clip_span(int'(oy) + row * s, s, h, ya, yb)) continue;
                    addr = longint'(ya) * longint'(stride) + longint'(xa);
                    r.addr    = addr[sgr_pkg::PIX_ADDR_W-1:0];
                    r.x_first = xa[sgr_pkg::PIX_W-1:0];
                    r.y_first = ya[sgr_pkg::PIX_W-1:0];
                    r.x_last  = xb[sgr_pkg::PIX_W-1:0];
                    r.y_last  = yb[sgr_pkg::PIX_W-1:0];
                    r.color   = ink;
                    r.last    = 1'b0;
                    expected_rects.push_back(r);
                    added++;
                end
            end
            if (added > 0) expected_rects[expected_rects.size()-1].last = 1'b1;
            pen += sgr_pkg::PEN_STEP * s;
            if (pen > sgr_pkg::PEN_MAX) pen = sgr_pkg::PEN_MAX;
        endfunction

        function void same(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_rect(logic [sgr_pkg::OUT_DATA_W-1:0] d, logic last);
            t_rect_exp e;
            if (expected_rects.size() == 0) begin
                $display("%0t: unexpected rect, expected none, actual 0x%0h last %0b",
                         $time, d, last);
                errors++;
                return;
            end
            e = expected_rects.pop_front();
            same("pixel_address", e.addr, d[23:0]);
            same("x_first", e.x_first, d[35:24]);
            same("y_first", e.y_first, d[47:36]);
            same("x_last", e.x_last, d[59:48]);
            same("y_last", e.y_last, d[71:60]);
            same("fill_color", e.color, d[103:72]);
            same("last_rect", e.last, last);
        endfunction

        function int pending();
            return expected_rects.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [sgr_pkg::IN_DATA_W-1:0]   i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [sgr_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic                            o_m_tlast;
    logic                            i_cfg_we;
    logic [sgr_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [sgr_pkg::COLOR_W-1:0]     i_cfg_data;

    rect_predictor sb = new();
    bit calm;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;
    int hold_left = 0;

    scaled_glyph_rectangle_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("scaled_glyph_rectangle_generator verification failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (squeeze_req && !squeeze_done) begin
            hold_left = 500;
            squeeze_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_rect(o_m_tdata, o_m_tlast);
    end

    task automatic send_char(logic [7:0] code, bit ns, int ox, int oy, int sc);
        logic [12:0] ox13;
        logic [12:0] oy13;
        logic [3:0]  sc4;
        ox13 = ox[12:0];
        oy13 = oy[12:0];
        sc4  = sc[3:0];
        while (!calm && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, sc4, oy13, ox13, code};
        i_s_tuser  <= ns;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.take_char(code, ns, ox13, oy13, sc4);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0 || !o_s_tready) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic load_screen(int w, int h, int stride, logic [31:0] ink);
        logic [31:0] vals [4];
        vals = '{w, h, stride, ink};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= sgr_pkg::CFG_INDEX_W'(i);
            i_cfg_data  <= vals[i];
            sb.set_reg(sgr_pkg::t_cfg_reg'(i), vals[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(9))
            0: return int'($urandom_range(8191));
            1: return sgr_pkg::CLIP_MAX;
            2: return int'($urandom_range(1, 40));
            default: return int'($urandom_range(64, 1920));
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(9))
            0, 1: return 8'($urandom_range(255));
            2: return 8'h20;
            3, 4, 5: return sgr_pkg::CHAR_ZERO + 8'($urandom_range(9));
            default: return sgr_pkg::CHAR_A + 8'($urandom_range(25));
        endcase
    endfunction

    // coordinate near the visible span so clipping happens often
    function automatic int pick_coord(int lim);
        int v;
        if ($urandom_range(9) == 0) return int'($urandom_range(8191)) - 4096;
        if (lim > sgr_pkg::CLIP_MAX) lim = sgr_pkg::CLIP_MAX;
        v = int'($urandom_range(lim + 80)) - 64;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    function automatic int pick_scale();
        if ($urandom_range(19) == 0) return 0;
        if ($urandom_range(3) == 0) return int'($urandom_range(1, 15));
        return int'($urandom_range(1, 4));
    endfunction

    initial begin
        int w, h;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset screen
        send_char("A", 1, 0, 0, 1);
        send_char("8", 0, 0, 100, 15);
        send_char("Z", 1, 500, 0, 0);
        send_char("M", 0, 0, 20, 2);
        send_char(" ", 0, 0, 20, 3);
        send_char(8'hff, 0, 0, 20, 7);
        send_char(8'h00, 0, 0, 20, 7);
        send_char("@", 0, 0, 20, 1);
        send_char("[", 0, 0, 20, 1);
        send_char("/", 0, 0, 20, 1);
        send_char(":", 0, 0, 20, 1);
        send_char("W", 1, -4096, -4096, 15);
        send_char("H", 1, -6, -6, 4);
        send_char("0", 1, 1915, 1075, 3);
        send_char("Q", 1, 4095, 4095, 15);
        send_char("9", 1, 1910, -20, 5);
        send_char("B", 0, 0, 0, 5);
        settle();
        // zero screen width
        load_screen(0, 4096, 100, 32'h12345678);
        send_char("A", 1, 0, 0, 1);
        send_char("8", 1, 10, 10, 2);
        settle();
        // oversized screen
        load_screen(8191, 8191, 8191, 32'hffffffff);
        send_char("X", 1, 4080, 4080, 15);
        send_char("E", 1, -3, 0, 15);
        settle();
        // one-pixel screen, zero stride
        load_screen(1, 1, 0, 32'h00000000);
        send_char("A", 1, 0, -1, 1);
        send_char("1", 1, 0, 0, 1);
        settle();

        for (int chunk = 0; chunk < 6; chunk++) begin
            w = pick_dim();
            h = pick_dim();
            load_screen(w, h, ($urandom_range(2) == 0) ? int'($urandom_range(8191)) : w,
                        $urandom);
            calm = (chunk == 4);
            if (chunk == 2) squeeze_req = 1'b1;
            for (int k = 0; k < 25; k++) begin
                send_char(pick_code(), ($urandom_range(4) == 0), pick_coord(w),
                          pick_coord(h), pick_scale());
            end
            settle();
        end
        calm = 1'b0;

        // long line runs the pen into saturation and past it
        load_screen(4096, 64, 4096, $urandom);
        send_char("W", 1, 4095, 0, 15);
        for (int k = 0; k < 325; k++) begin
            send_char(sgr_pkg::CHAR_A + 8'($urandom_range(25)), 0, 0, 0, 15);
        end
        send_char("8", 0, 0, 0, 1);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("scaled_glyph_rectangle_generator verification clean");
        end else begin
            $display("scaled_glyph_rectangle_generator verification failed");
        end
        $finish;
    end

endmodule
